// ===== hdl/sdr_pkg.sv =====
// package for the slip deframer with receive ring
// holds ring sizing, slip byte codes, item kinds, the frame counter width and result type
// no dependencies
`default_nettype none

package sdr_pkg;

    localparam int RING_DEPTH = 256;
    localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int RING_CW    = $clog2(RING_DEPTH + 1);

    localparam int FRAME_CW   = 9;
    localparam logic [FRAME_CW-1:0] FRAME_MAX = '1;

    localparam logic [7:0] SLIP_END     = 8'hC0;
    localparam logic [7:0] SLIP_ESC     = 8'hDB;
    localparam logic [7:0] SLIP_END_ESC = 8'hDC;
    localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

    localparam logic KIND_LINE = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef struct packed {
        logic                frame_end;
        logic [FRAME_CW-1:0] frame_length;
        logic                read_valid;
    } t_result;

endpackage

`default_nettype wire

// ===== hdl/sdr_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module sdr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                           i_wr_data,
    input  wire logic                                       i_rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                           o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/slip_deframer_with_rx_ring_core.sv =====
// slip receive deframer: decodes escapes, keeps decoded bytes in a ring ram, reports frame
// lengths on END and pops stored bytes on read items; depends on sdr_pkg and sdr_ram
// an accepted item goes through the p1 register, then the output register, to o_out_valid
// throughput: one item per cycle unless stalled; ram takes one write, one read a cycle
// reset: synchronous active-low, clears head, count, frame count, escape and pipe
// ring contents are not cleared; no clearing pass, items are taken right after reset
`default_nettype none

module slip_deframer_with_rx_ring_core
    import sdr_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic                i_kind,
    input  wire logic [7:0]          i_line_byte,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic                     o_frame_end,
    output logic [FRAME_CW-1:0]      o_frame_length,
    output logic                     o_read_valid,
    output logic [7:0]               o_read_byte
);

    logic [RING_AW-1:0]  r_head, n_head;
    logic [RING_CW-1:0]  r_count, n_count;
    logic [FRAME_CW-1:0] r_frame, n_frame;
    logic                r_esc, n_esc;

    logic    r_p1_valid, n_p1_valid;
    t_result r_p1, n_p1;
    logic    r_out_valid;
    t_result r_out;
    logic [7:0] r_out_byte;

    logic               accept;
    logic               out_load;
    logic               p1_move;
    logic               wr_en;
    logic [7:0]         wr_data;
    logic [RING_AW-1:0] wr_addr;
    logic               rd_en;
    logic [7:0]         rd_data;
    logic               store;
    logic [7:0]         store_byte;
    logic               ring_full;
    logic [RING_AW:0]   tail_sum;
    logic [RING_AW-1:0] tail;
    logic [RING_AW-1:0] head_inc;

    // output stage frees up when empty or drained; p1 moves into it
    assign out_load   = !r_out_valid || i_out_ready;
    assign p1_move    = r_p1_valid && out_load;
    assign o_in_ready = !r_p1_valid || out_load;
    assign accept     = i_in_valid && o_in_ready;

    assign ring_full = (r_count == RING_CW'(RING_DEPTH));
    assign tail_sum  = (RING_AW+1)'(r_head) + (RING_AW+1)'(r_count);
    assign tail      = (tail_sum >= (RING_AW+1)'(RING_DEPTH))
                       ? RING_AW'(tail_sum - (RING_AW+1)'(RING_DEPTH))
                       : RING_AW'(tail_sum);
    assign head_inc  = (r_head == RING_AW'(RING_DEPTH - 1)) ? '0 : r_head + 1'b1;

    always_comb begin
        n_head     = r_head;
        n_count    = r_count;
        n_frame    = r_frame;
        n_esc      = r_esc;
        store      = 1'b0;
        store_byte = i_line_byte;
        rd_en      = 1'b0;
        n_p1       = r_p1;
        n_p1_valid = r_p1_valid && !p1_move;

        if (accept) begin
            if (i_kind == KIND_READ) begin
                n_p1_valid        = 1'b1;
                n_p1.frame_end    = 1'b0;
                n_p1.frame_length = '0;
                n_p1.read_valid   = (r_count != '0);
                if (r_count != '0) begin
                    rd_en   = 1'b1;
                    n_head  = head_inc;
                    n_count = r_count - 1'b1;
                end
            end else if (i_line_byte == SLIP_END) begin
                // END leaves a pending escape alone
                n_p1_valid        = 1'b1;
                n_p1.frame_end    = 1'b1;
                n_p1.frame_length = r_frame;
                n_p1.read_valid   = 1'b0;
                n_frame           = '0;
            end else if (r_esc) begin
                n_esc = 1'b0;
                if (i_line_byte == SLIP_END_ESC) begin
                    store      = 1'b1;
                    store_byte = SLIP_END;
                end else if (i_line_byte == SLIP_ESC_ESC) begin
                    store      = 1'b1;
                    store_byte = SLIP_ESC;
                end
            end else if (i_line_byte == SLIP_ESC) begin
                n_esc = 1'b1;
            end else begin
                store = 1'b1;
            end

            if (store) begin
                if (ring_full) begin
                    // overwrite the oldest byte, frame count holds
                    n_head = head_inc;
                end else begin
                    n_count = r_count + 1'b1;
                    if (r_frame != FRAME_MAX) begin
                        n_frame = r_frame + 1'b1;
                    end
                end
            end
        end
    end

    assign wr_en   = store;
    assign wr_data = store_byte;
    assign wr_addr = ring_full ? r_head : tail;

    sdr_ram #(
        .WIDTH (8),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_head),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_frame     <= '0;
            r_esc       <= 1'b0;
            r_p1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_head     <= n_head;
            r_count    <= n_count;
            r_frame    <= n_frame;
            r_esc      <= n_esc;
            r_p1_valid <= n_p1_valid;
            if (out_load) begin
                r_out_valid <= r_p1_valid;
            end
        end
        r_p1 <= n_p1;
        if (p1_move) begin
            r_out      <= r_p1;
            r_out_byte <= r_p1.read_valid ? rd_data : 8'h00;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_frame_end    = r_out.frame_end;
    assign o_frame_length = r_out.frame_length;
    assign o_read_valid   = r_out.read_valid;
    assign o_read_byte    = r_out_byte;

    // ring never holds more than its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= RING_CW'(RING_DEPTH))
        else $error("ring count above depth");

    // ram read data must hold while p1 waits for the output stage
    a_rd_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p1_valid && !out_load) |-> !rd_en)
        else $error("ram read while p1 stalled");

    // one item never both writes and reads the ring
    a_rw_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(wr_en && rd_en))
        else $error("ring written and read by one item");

    // a result is a frame end or a read, never both
    a_res_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.frame_end && r_out.read_valid))
        else $error("result carries frame end and read");

    // popping from an empty ring is impossible
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |-> (r_count != '0))
        else $error("pop from empty ring");

endmodule

`default_nettype wire

// ===== sim/slip_deframer_with_rx_ring_core_test.sv =====
`timescale 1ns / 100ps
// self-checking bench for slip_deframer_with_rx_ring_core: slip line bytes and read items
// in, frame lengths and popped bytes out, checked against a local ring decoder or typed rows
// depends on sdr_pkg and the core rtl
module slip_deframer_with_rx_ring_core_test
    import sdr_pkg::*;
();

    typedef struct packed {
        logic                frame_end;
        logic [FRAME_CW-1:0] frame_length;
        logic                read_valid;
        logic [7:0]          read_byte;
    } t_deframe_result;

    typedef struct packed {
        logic            kind;
        logic [7:0]      line_b;
        logic            typed_in;
        t_deframe_result want;
    } t_stim_row;

    localparam int N_ROWS     = 25;
    localparam int RAND_ITEMS = 925;
    localparam int MODE_ITEMS = 150;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                i_kind      = KIND_LINE;
    logic [7:0]          i_line_byte = 8'h00;
    logic                i_out_ready = 1'b0;
    logic                o_in_ready;
    logic                o_out_valid;
    logic                o_frame_end;
    logic [FRAME_CW-1:0] o_frame_length;
    logic                o_read_valid;
    logic [7:0]          o_read_byte;

    slip_deframer_with_rx_ring_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_kind         (i_kind),
        .i_line_byte    (i_line_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_frame_end    (o_frame_end),
        .o_frame_length (o_frame_length),
        .o_read_valid   (o_read_valid),
        .o_read_byte    (o_read_byte)
    );

    always #2 i_clk = ~i_clk;

    // local decoder state
    logic [7:0]          ring_mem [RING_DEPTH];
    int                  ring_rd   = 0;
    int                  ring_fill = 0;
    logic [FRAME_CW-1:0] frame_cnt = '0;
    logic                esc_pend  = 1'b0;

    t_deframe_result pending_results [$];
    t_stim_row       script [N_ROWS];
    int              mismatch_count = 0;
    int              items_sent     = 0;
    int              pace_mode      = 0;

    // returns 1 when the item produces a result
    function automatic bit decode_item(input logic k, input logic [7:0] b,
                                       output t_deframe_result r);
        logic       do_store;
        logic [7:0] val;
        r = '0;
        do_store = 1'b0;
        val = b;
        if (k == KIND_READ) begin
            if (ring_fill > 0) begin
                r.read_valid = 1'b1;
                r.read_byte  = ring_mem[ring_rd];
                ring_rd      = (ring_rd + 1) % RING_DEPTH;
                ring_fill--;
            end
            return 1'b1;
        end
        // END closes the frame but leaves a pending escape alone
        if (b == SLIP_END) begin
            r.frame_end    = 1'b1;
            r.frame_length = frame_cnt;
            frame_cnt      = '0;
            return 1'b1;
        end
        if (esc_pend) begin
            esc_pend = 1'b0;
            if (b == SLIP_END_ESC) begin
                do_store = 1'b1;
                val = SLIP_END;
            end else if (b == SLIP_ESC_ESC) begin
                do_store = 1'b1;
                val = SLIP_ESC;
            end
        end else if (b == SLIP_ESC) begin
            esc_pend = 1'b1;
        end else begin
            do_store = 1'b1;
        end
        if (do_store) begin
            if (ring_fill < RING_DEPTH) begin
                ring_mem[(ring_rd + ring_fill) % RING_DEPTH] = val;
                ring_fill++;
                if (frame_cnt != FRAME_MAX) frame_cnt++;
            end else begin
                // full ring: overwrite oldest, frame count stays
                ring_mem[ring_rd] = val;
                ring_rd = (ring_rd + 1) % RING_DEPTH;
            end
        end
        return 1'b0;
    endfunction

    function automatic bit sender_idle();
        if (pace_mode == 1) return $urandom_range(99) < 56;
        if (pace_mode == 3) return $urandom_range(99) < 24;
        return 1'b0;
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(9))
            0: return SLIP_END;
            1: return SLIP_ESC;
            2: return SLIP_END_ESC;
            3: return SLIP_ESC_ESC;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic t_stim_row row(input logic k, input logic [7:0] b, input logic typed_in,
                                      input logic fe, input int fl, input logic rv,
                                      input logic [7:0] rb);
        t_stim_row s;
        s.kind = k;
        s.line_b = b;
        s.typed_in = typed_in;
        s.want.frame_end = fe;
        s.want.frame_length = FRAME_CW'(fl);
        s.want.read_valid = rv;
        s.want.read_byte = rb;
        return s;
    endfunction

    // entered and left at a falling edge
    task automatic push_item(input logic k, input logic [7:0] b,
                             input logic typed_in, input t_deframe_result want);
        t_deframe_result got;
        while (sender_idle()) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_kind      <= k;
        i_line_byte <= b;
        do @(posedge i_clk); while (!o_in_ready);
        if (decode_item(k, b, got)) pending_results.push_back(typed_in ? want : got);
        items_sent++;
        pace_mode = (items_sent / MODE_ITEMS) % 4;
        @(negedge i_clk);
    endtask

    task automatic push_read();
        push_item(KIND_READ, 8'($urandom_range(255)), 1'b0, '0);
    endtask

    task automatic push_line(input logic [7:0] b);
        push_item(KIND_LINE, b, 1'b0, '0);
    endtask

    // one payload byte, escaped as the line would carry it
    task automatic send_escaped(input logic [7:0] d);
        if (d == SLIP_END) begin
            push_line(SLIP_ESC);
            push_line(SLIP_END_ESC);
        end else if (d == SLIP_ESC) begin
            push_line(SLIP_ESC);
            push_line(SLIP_ESC_ESC);
        end else begin
            push_line(d);
        end
    endtask

    always @(negedge i_clk) begin
        if (pace_mode == 2) i_out_ready <= $urandom_range(99) >= 56;
        else if (pace_mode == 3) i_out_ready <= $urandom_range(99) >= 24;
        else i_out_ready <= 1'b1;
    end

    always @(posedge i_clk) begin : check_results
        t_deframe_result exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: end %b len %0d valid %b byte %h", $time,
                         o_frame_end, o_frame_length, o_read_valid, o_read_byte);
                mismatch_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (o_frame_end !== exp_r.frame_end) begin
                    $display("%0t: frame_end expected %b actual %b", $time,
                             exp_r.frame_end, o_frame_end);
                    mismatch_count++;
                end
                if (o_frame_length !== exp_r.frame_length) begin
                    $display("%0t: frame_length expected %0d actual %0d", $time,
                             exp_r.frame_length, o_frame_length);
                    mismatch_count++;
                end
                if (o_read_valid !== exp_r.read_valid) begin
                    $display("%0t: read_valid expected %b actual %b", $time,
                             exp_r.read_valid, o_read_valid);
                    mismatch_count++;
                end
                if (o_read_byte !== exp_r.read_byte) begin
                    $display("%0t: read_byte expected %h actual %h", $time,
                             exp_r.read_byte, o_read_byte);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int n;

        script[0]  = row(KIND_READ, 8'h00, 1'b1, 1'b0, 0, 1'b0, 8'h00);
        script[1]  = row(KIND_LINE, SLIP_END, 1'b1, 1'b1, 0, 1'b0, 8'h00);
        script[2]  = row(KIND_LINE, 8'h00, 1'b0, 1'b0, 0, 1'b0, 8'h00);
        script[3]  = row(KIND_LINE, 8'hFF, 1'b0, 1'b0, 0, 1'b0, 8'h00);
        script[4]  = row(KIND_LINE, SLIP_ESC, 1'b0, 1'b0, 0, 1'b0, 8'h00);
        script[5]  = row(KIND_LINE, SLIP_END_ESC, 1'b0, 1'b0, 0, 1'b0, 8'h00);
        script[6]  = row(KIND_LINE, SLIP_ESC, 1'b0, 1'b0, 0, 1'b0, 8'h00);
        script[7]  = row(KIND_LINE, SLIP_ESC_ESC, 1'b0, 1'b0, 0, 1'b0, 8'h00);
        // unknown escape, then a doubled escape: both dropped
        script[8]  = row(KIND_LINE, SLIP_ESC, 1'b0, 1'b0, 0, 1'b0, 8'h00);
        script[9]  = row(KIND_LINE, 8'h41, 1'b0, 1'b0, 0, 1'b0, 8'h00);
        script[10] = row(KIND_LINE, SLIP_ESC, 1'b0, 1'b0, 0, 1'b0, 8'h00);
        script[11] = row(KIND_LINE, SLIP_ESC, 1'b0, 1'b0, 0, 1'b0, 8'h00);
        script[12] = row(KIND_LINE, SLIP_END, 1'b1, 1'b1, 4, 1'b0, 8'h00);
        // end inside an escape: frame closes, escape still pending
        script[13] = row(KIND_LINE, SLIP_ESC, 1'b0, 1'b0, 0, 1'b0, 8'h00);
        script[14] = row(KIND_LINE, SLIP_END, 1'b1, 1'b1, 0, 1'b0, 8'h00);
        script[15] = row(KIND_LINE, SLIP_END_ESC, 1'b0, 1'b0, 0, 1'b0, 8'h00);
        script[16] = row(KIND_LINE, 8'h55, 1'b0, 1'b0, 0, 1'b0, 8'h00);
        script[17] = row(KIND_LINE, SLIP_END, 1'b0, 1'b0, 0, 1'b0, 8'h00);
        // line byte ignored on a read
        script[18] = row(KIND_READ, SLIP_END, 1'b0, 1'b0, 0, 1'b0, 8'h00);
        for (int i = 19; i < 24; i++) script[i] = row(KIND_READ, 8'hA5, 1'b0, 1'b0, 0, 1'b0, 8'h00);
        script[24] = row(KIND_READ, 8'hFF, 1'b1, 1'b0, 0, 1'b0, 8'h00);

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (script[i]) push_item(script[i].kind, script[i].line_b,
                                      script[i].typed_in, script[i].want);

        // ring is empty here: flood it past full, then hold it near full with
        // read/write pairs until the frame counter hits its ceiling
        push_line(SLIP_END);
        repeat (RING_DEPTH + 4) push_line(8'($urandom_range(8'hBF)));
        repeat (int'(FRAME_MAX) - RING_DEPTH + 10) begin
            push_read();
            push_line(8'($urandom_range(8'hBF)));
        end
        push_line(SLIP_END);

        while (items_sent < N_ROWS + RAND_ITEMS) begin
            case ($urandom_range(19))
                0, 1, 2, 3, 4, 5, 6, 7: begin
                    n = ($urandom_range(7) == 0) ? $urandom_range(40) : $urandom_range(12);
                    repeat (n) send_escaped(pick_byte());
                    push_line(SLIP_END);
                end
                8, 9, 10, 11: begin
                    repeat ($urandom_range(1, 16)) push_read();
                end
                12, 13, 14: begin
                    repeat ($urandom_range(1, 8)) begin
                        if ($urandom_range(1)) push_read();
                        else push_line($urandom_range(1) ? pick_byte()
                                                         : 8'($urandom_range(255)));
                    end
                end
                15, 16, 17: begin
                    // broken escapes, sometimes with an end in between
                    push_line(SLIP_ESC);
                    if ($urandom_range(2) == 0) push_line(SLIP_END);
                    push_line(pick_byte());
                    if ($urandom_range(1)) push_line(SLIP_END);
                end
                18: begin
                    repeat ($urandom_range(RING_DEPTH - 6, RING_DEPTH + 14))
                        send_escaped(pick_byte());
                    push_line(SLIP_END);
                end
                default: begin
                    n = ring_fill + 1;
                    repeat (n) push_read();
                end
            endcase
        end

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/sdr_pkg.sv
hdl/sdr_ram.sv
hdl/slip_deframer_with_rx_ring_core.sv
sim/slip_deframer_with_rx_ring_core_test.sv
